>>> rtl/core/ps2mpc_pkg.sv
// ps2mpc_pkg: shared types and constants of the ps2 mouse packet cursor unit
// no dependencies; used by the framer, the cursor datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package ps2mpc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 12;
	localparam int unsigned CALC_W = POS_W + 2;
	localparam int unsigned OUT_W  = 32;

	localparam logic [POS_W-1:0] HOME_POS      = 12'd100;
	localparam logic [POS_W-1:0] X_LIMIT_RESET = 12'd1023;
	localparam logic [POS_W-1:0] Y_LIMIT_RESET = 12'd767;

	// header byte bit positions
	localparam int unsigned LEFT_BIT   = 0;
	localparam int unsigned RIGHT_BIT  = 1;
	localparam int unsigned MIDDLE_BIT = 2;
	localparam int unsigned SYNC_BIT   = 3;
	localparam int unsigned XSIGN_BIT  = 4;
	localparam int unsigned YSIGN_BIT  = 5;
	localparam int unsigned XOVF_BIT   = 6;
	localparam int unsigned YOVF_BIT   = 7;

	// configuration register indexes
	localparam logic CFG_X_LIMIT = 1'b0;
	localparam logic CFG_Y_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DX   = 2'd1,
		PH_DY   = 2'd2
	} phase_t;

	// completed packet, framer to cursor datapath
	typedef struct packed {
		logic              done;
		logic [BYTE_W-1:0] head;
		logic [BYTE_W-1:0] dx;
		logic [BYTE_W-1:0] dy;
	} pkt_t;

	typedef struct packed {
		logic             move_rejected;
		logic             overflow;
		logic [POS_W-1:0] cursor_y;
		logic [POS_W-1:0] cursor_x;
		logic             middle_button;
		logic             right_button;
		logic             left_button;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/core/ps2mpc_framer.sv
// ps2mpc_framer: three-byte packet framing with sync on header bit 3
// depends on ps2mpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ps2mpc_framer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire logic [ps2mpc_pkg::BYTE_W-1:0] data_byte,
	output ps2mpc_pkg::pkt_t                   pkt
);

	ps2mpc_pkg::phase_t phase_q, phase_d;
	logic [ps2mpc_pkg::BYTE_W-1:0] head_q;
	logic [ps2mpc_pkg::BYTE_W-1:0] dx_q;

	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			case (phase_q)
				ps2mpc_pkg::PH_DX: phase_d = ps2mpc_pkg::PH_DY;
				ps2mpc_pkg::PH_DY: phase_d = ps2mpc_pkg::PH_IDLE;
				default: begin
					// out of sync bytes are dropped while idle
					phase_d = data_byte[ps2mpc_pkg::SYNC_BIT] ? ps2mpc_pkg::PH_DX
						: ps2mpc_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		pkt.done = fire && (phase_q == ps2mpc_pkg::PH_DY);
		pkt.head = head_q;
		pkt.dx   = dx_q;
		pkt.dy   = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ps2mpc_pkg::PH_IDLE;
			head_q  <= '0;
			dx_q    <= '0;
		end else begin
			phase_q <= phase_d;
			if (fire && (phase_q != ps2mpc_pkg::PH_DX) && (phase_q != ps2mpc_pkg::PH_DY)
				&& data_byte[ps2mpc_pkg::SYNC_BIT]) begin
				head_q <= data_byte;
			end
			if (fire && (phase_q == ps2mpc_pkg::PH_DX)) begin
				dx_q <= data_byte;
			end
		end
	end

`ifndef SYNTHESIS
	a_idle_drop: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q == ps2mpc_pkg::PH_IDLE) && !data_byte[ps2mpc_pkg::SYNC_BIT]
		|=> phase_q == ps2mpc_pkg::PH_IDLE)
		else $error("framer left idle on a byte without sync bit");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ps2mpc_cursor.sv
// ps2mpc_cursor: cursor position, limit registers and bounded move check
// depends on ps2mpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ps2mpc_cursor (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [ps2mpc_pkg::POS_W-1:0] cfg_data,
	input  ps2mpc_pkg::pkt_t                  pkt,
	output ps2mpc_pkg::res_t                  res
);

	localparam int unsigned CW = ps2mpc_pkg::CALC_W;
	localparam int unsigned PW = ps2mpc_pkg::POS_W;

	logic [PW-1:0] pos_x_q, pos_y_q, x_limit_q, y_limit_q;
	logic signed [CW-1:0] dx_ext, dy_ext, nx, ny;
	logic ovf, rej, commit;

	always_comb begin
		// 9-bit deltas: sign from header, low bits from the data bytes
		dx_ext = CW'(signed'({pkt.head[ps2mpc_pkg::XSIGN_BIT], pkt.dx}));
		dy_ext = CW'(signed'({pkt.head[ps2mpc_pkg::YSIGN_BIT], pkt.dy}));
		nx = signed'(CW'(pos_x_q)) + dx_ext;
		ny = signed'(CW'(pos_y_q)) - dy_ext;
		ovf = pkt.head[ps2mpc_pkg::XOVF_BIT] | pkt.head[ps2mpc_pkg::YOVF_BIT];
		rej = !ovf && (nx < 0 || nx > signed'(CW'(x_limit_q))
			|| ny < 0 || ny > signed'(CW'(y_limit_q)));
		commit = pkt.done && !ovf && !rej;

		res.left_button   = pkt.head[ps2mpc_pkg::LEFT_BIT];
		res.right_button  = pkt.head[ps2mpc_pkg::RIGHT_BIT];
		res.middle_button = pkt.head[ps2mpc_pkg::MIDDLE_BIT];
		res.cursor_x      = commit ? nx[PW-1:0] : pos_x_q;
		res.cursor_y      = commit ? ny[PW-1:0] : pos_y_q;
		res.overflow      = ovf;
		res.move_rejected = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= ps2mpc_pkg::HOME_POS;
			pos_y_q   <= ps2mpc_pkg::HOME_POS;
			x_limit_q <= ps2mpc_pkg::X_LIMIT_RESET;
			y_limit_q <= ps2mpc_pkg::Y_LIMIT_RESET;
		end else begin
			if (commit) begin
				pos_x_q <= nx[PW-1:0];
				pos_y_q <= ny[PW-1:0];
			end
			if (cfg_we) begin
				case (cfg_index)
					ps2mpc_pkg::CFG_X_LIMIT: x_limit_q <= cfg_data;
					ps2mpc_pkg::CFG_Y_LIMIT: y_limit_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_hold_on_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		pkt.done && (ovf || rej) |=> $stable(pos_x_q) && $stable(pos_y_q))
		else $error("cursor moved on overflow or rejected packet");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ps2_mouse_packet_cursor_unit.sv
// ps2 mouse packet cursor unit: top level, byte input stage and result register
// depends on ps2mpc_pkg, ps2mpc_framer and ps2mpc_cursor
// a third packet byte gives its result through the input register, then the
//   result register; first and second bytes give none
// throughput: one byte per cycle; a held result stalls input only once the
//   input register is also full
// reset (arst_n low, async): idle framing, cursor at (100,100), limits 1023 x 767
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_cursor_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// byte stream in
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte

	// packet results out
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] left_button, [1] right_button, [2] middle_button, [14:3] cursor_x,
	// [26:15] cursor_y, [27] overflow, [28] move_rejected, [31:29] zero
	output logic [ps2mpc_pkg::OUT_W-1:0] m_axis_tdata,

	// limit registers: index 0 x_limit, index 1 y_limit
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data
);

	localparam int unsigned RES_W = $bits(ps2mpc_pkg::res_t);

	// input register stage
	logic                          valid_s1;
	logic [ps2mpc_pkg::BYTE_W-1:0] byte_s1;
	logic                          advance;

	// result register
	logic             res_valid_q;
	ps2mpc_pkg::res_t res_q;

	ps2mpc_pkg::pkt_t pkt;
	ps2mpc_pkg::res_t res;

	// the held byte moves on when the result register is free or being drained
	assign advance       = valid_s1 && (!res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	ps2mpc_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.data_byte (byte_s1),
		.pkt       (pkt)
	);

	ps2mpc_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pkt       (pkt),
		.res       (res)
	);

	// result register: load on a completed packet, clear on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pkt.done) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.done) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {{(ps2mpc_pkg::OUT_W - RES_W){1'b0}}, res_q};

`ifndef SYNTHESIS
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.overflow && res_q.move_rejected))
		else $error("overflow and move_rejected both set");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a stalled byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		pkt.done |-> !res_valid_q || m_axis_tready)
		else $error("result register overwritten before transfer");
`endif

endmodule

`default_nettype wire
